[rtl/core/atm_pkg.sv]
// Package for the alarm table matcher: request/response payloads, command and
// status codes, table entry layout and the microcode control word format.
// No dependencies.
package atm_pkg;

    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SLOT_W   = 5;
    localparam int COUNT_W  = 5;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_CHECK  = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_BAD  = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t                command;
        logic [HOUR_W-1:0]   alarm_hour;
        logic [MINUTE_W-1:0] alarm_minute;
        logic [SLOT_W-1:0]   slot;
        logic [HOUR_W-1:0]   now_hour;
        logic [MINUTE_W-1:0] now_minute;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic                ring;
        logic [SLOT_W-1:0]   rang_slot;
        logic [COUNT_W-1:0]  alarm_count;
        logic [HOUR_W-1:0]   entry_hour;
        logic [MINUTE_W-1:0] entry_minute;
        logic                entry_alerted;
    } rsp_t;

    // One table entry as held in the RAM
    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic                alerted;
    } entry_t;

    // Microcode fields
    typedef enum logic [1:0] {RD_NONE, RD_IDX, RD_IDX_P1, RD_SLOT} rd_src_t;
    typedef enum logic [1:0] {WR_NONE, WR_ADD, WR_MOVE, WR_CHECK} wr_src_t;
    typedef enum logic [1:0] {IDX_HOLD, IDX_ZERO, IDX_SLOT, IDX_INC} idx_op_t;
    typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} cnt_op_t;
    typedef enum logic [2:0] {RES_NONE, RES_FULL, RES_BAD, RES_RING, RES_ENTRY} res_op_t;
    typedef enum logic [2:0] {
        COND_ALWAYS, COND_FULL, COND_BAD_SLOT, COND_IDX_END, COND_MOVE_END, COND_FIRE
    } cond_t;

    typedef enum logic [3:0] {
        ST_A_TEST, ST_A_FULL, ST_A_WRITE,
        ST_D_TEST, ST_D_START, ST_D_LOOP, ST_D_MOVE,
        ST_C_START, ST_C_LOOP, ST_C_EVAL, ST_C_RING,
        ST_R_TEST, ST_R_ADDR, ST_R_GET,
        ST_BAD, ST_DONE
    } step_t;

    // next step = condition ? tgt : alt; finish hands the result over
    typedef struct packed {
        rd_src_t rd;
        wr_src_t wr;
        idx_op_t idx;
        cnt_op_t cnt;
        res_op_t res;
        cond_t   cond;
        step_t   tgt;
        step_t   alt;
        logic    finish;
    } ctrl_word_t;

    localparam ctrl_word_t CW_NOP = '{
        rd: RD_NONE, wr: WR_NONE, idx: IDX_HOLD, cnt: CNT_HOLD, res: RES_NONE,
        cond: COND_ALWAYS, tgt: ST_DONE, alt: ST_DONE, finish: 1'b0
    };

    typedef struct packed {
        ctrl_word_t cw;
        logic       start;
        logic       load;
    } seq_ctrl_t;

    typedef struct packed {
        logic full;
        logic bad_slot;
        logic idx_end;
        logic move_end;
        logic fire;
    } dp_flags_t;

    // Alarm h:m is at or before current time nh:nm
    function automatic logic alarm_passed(
        input logic [HOUR_W-1:0]   h,
        input logic [MINUTE_W-1:0] m,
        input logic [HOUR_W-1:0]   nh,
        input logic [MINUTE_W-1:0] nm
    );
        return (h < nh) || ((h == nh) && (m <= nm));
    endfunction

endpackage

[rtl/core/atm_if.sv]
// Valid/ready channel interfaces for the alarm table matcher.
// Depends on atm_pkg for the payload types.
interface atm_req_if;
    logic          valid;
    logic          ready;
    atm_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface atm_rsp_if;
    logic          valid;
    logic          ready;
    atm_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/atm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module atm_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 20
) (
    input  logic                                          clk,
    input  logic                                          wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
    input  logic [WIDTH-1:0]                              wr_data,
    input  logic                                          rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
    output logic [WIDTH-1:0]                              rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

[rtl/core/atm_seq.sv]
// Microcode sequencer: control ROM, step counter, condition select and the
// request/response handshake control. Depends on atm_pkg.
module atm_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  atm_pkg::cmd_t       req_command,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    input  atm_pkg::dp_flags_t  flags,
    output atm_pkg::seq_ctrl_t  ctrl
);
    typedef enum logic [1:0] {S_IDLE, S_RUN, S_HOLD} seq_state_t;

    seq_state_t          state_reg, state_next;
    atm_pkg::step_t      step_reg, step_next;
    logic                out_valid_reg, out_valid_next;
    atm_pkg::ctrl_word_t cw;
    logic                cond_true;
    logic                start;
    logic                load;
    logic                out_free;

    function automatic atm_pkg::ctrl_word_t micro_rom(input atm_pkg::step_t step);
        atm_pkg::ctrl_word_t w;
        w = atm_pkg::CW_NOP;
        unique case (step)
            atm_pkg::ST_A_TEST:
            begin
                w.cond = atm_pkg::COND_FULL;
                w.tgt  = atm_pkg::ST_A_FULL;
                w.alt  = atm_pkg::ST_A_WRITE;
            end
            atm_pkg::ST_A_FULL:
            begin
                w.res    = atm_pkg::RES_FULL;
                w.finish = 1'b1;
            end
            atm_pkg::ST_A_WRITE:
            begin
                w.wr     = atm_pkg::WR_ADD;
                w.cnt    = atm_pkg::CNT_INC;
                w.finish = 1'b1;
            end
            atm_pkg::ST_D_TEST:
            begin
                w.cond = atm_pkg::COND_BAD_SLOT;
                w.tgt  = atm_pkg::ST_BAD;
                w.alt  = atm_pkg::ST_D_START;
            end
            atm_pkg::ST_D_START:
            begin
                w.cnt = atm_pkg::CNT_DEC;
                w.idx = atm_pkg::IDX_SLOT;
                w.tgt = atm_pkg::ST_D_LOOP;
            end
            atm_pkg::ST_D_LOOP:
            begin
                w.rd   = atm_pkg::RD_IDX_P1;
                w.cond = atm_pkg::COND_MOVE_END;
                w.tgt  = atm_pkg::ST_DONE;
                w.alt  = atm_pkg::ST_D_MOVE;
            end
            atm_pkg::ST_D_MOVE:
            begin
                w.wr  = atm_pkg::WR_MOVE;
                w.idx = atm_pkg::IDX_INC;
                w.tgt = atm_pkg::ST_D_LOOP;
            end
            atm_pkg::ST_C_START:
            begin
                w.idx = atm_pkg::IDX_ZERO;
                w.tgt = atm_pkg::ST_C_LOOP;
            end
            atm_pkg::ST_C_LOOP:
            begin
                w.rd   = atm_pkg::RD_IDX;
                w.idx  = atm_pkg::IDX_INC;
                w.cond = atm_pkg::COND_IDX_END;
                w.tgt  = atm_pkg::ST_DONE;
                w.alt  = atm_pkg::ST_C_EVAL;
            end
            atm_pkg::ST_C_EVAL:
            begin
                // flag rewritten as the passed bit: clears future ones, marks the ringer
                w.wr   = atm_pkg::WR_CHECK;
                w.cond = atm_pkg::COND_FIRE;
                w.tgt  = atm_pkg::ST_C_RING;
                w.alt  = atm_pkg::ST_C_LOOP;
            end
            atm_pkg::ST_C_RING:
            begin
                w.res    = atm_pkg::RES_RING;
                w.finish = 1'b1;
            end
            atm_pkg::ST_R_TEST:
            begin
                w.cond = atm_pkg::COND_BAD_SLOT;
                w.tgt  = atm_pkg::ST_BAD;
                w.alt  = atm_pkg::ST_R_ADDR;
            end
            atm_pkg::ST_R_ADDR:
            begin
                w.rd  = atm_pkg::RD_SLOT;
                w.tgt = atm_pkg::ST_R_GET;
            end
            atm_pkg::ST_R_GET:
            begin
                w.res    = atm_pkg::RES_ENTRY;
                w.finish = 1'b1;
            end
            atm_pkg::ST_BAD:
            begin
                w.res    = atm_pkg::RES_BAD;
                w.finish = 1'b1;
            end
            atm_pkg::ST_DONE:
            begin
                w.finish = 1'b1;
            end
            default:
            begin
                w.finish = 1'b1;
            end
        endcase
        return w;
    endfunction

    function automatic atm_pkg::step_t entry_step(input atm_pkg::cmd_t cmd);
        atm_pkg::step_t s;
        unique case (cmd)
            atm_pkg::CMD_ADD:    s = atm_pkg::ST_A_TEST;
            atm_pkg::CMD_DELETE: s = atm_pkg::ST_D_TEST;
            atm_pkg::CMD_CHECK:  s = atm_pkg::ST_C_START;
            atm_pkg::CMD_READ:   s = atm_pkg::ST_R_TEST;
            default:             s = atm_pkg::ST_DONE;
        endcase
        return s;
    endfunction

    assign req_ready = (state_reg == S_IDLE);
    assign start     = req_valid && req_ready;
    assign out_free  = !out_valid_reg || rsp_ready;

    always_comb
    begin
        cw = (state_reg == S_RUN) ? micro_rom(step_reg) : atm_pkg::CW_NOP;

        unique case (cw.cond)
            atm_pkg::COND_ALWAYS:   cond_true = 1'b1;
            atm_pkg::COND_FULL:     cond_true = flags.full;
            atm_pkg::COND_BAD_SLOT: cond_true = flags.bad_slot;
            atm_pkg::COND_IDX_END:  cond_true = flags.idx_end;
            atm_pkg::COND_MOVE_END: cond_true = flags.move_end;
            atm_pkg::COND_FIRE:     cond_true = flags.fire;
            default:                cond_true = 1'b1;
        endcase

        state_next = state_reg;
        step_next  = step_reg;
        load       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_RUN;
                    step_next  = entry_step(req_command);
                end
            end
            S_RUN:
            begin
                if (cw.finish)
                begin
                    if (out_free)
                    begin
                        load       = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_HOLD;
                    end
                end
                else
                begin
                    step_next = cond_true ? cw.tgt : cw.alt;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= atm_pkg::ST_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid  = out_valid_reg;
    assign ctrl.cw    = cw;
    assign ctrl.start = start;
    assign ctrl.load  = load;
endmodule

[rtl/core/atm_dp.sv]
// Datapath: request capture, entry count, walk index, table RAM, result
// registers and output register. Depends on atm_pkg and atm_ram.
module atm_dp #(
    parameter int ALARM_SLOTS = 20
) (
    input  logic               clk,
    input  logic               rst_n,
    input  atm_pkg::seq_ctrl_t ctrl,
    input  atm_pkg::req_t      req_data,
    output atm_pkg::dp_flags_t flags,
    output atm_pkg::rsp_t      rsp_data
);
    localparam int IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
    localparam int CNT_W = $clog2(ALARM_SLOTS + 1);
    localparam int CMP_W = (CNT_W > atm_pkg::SLOT_W) ? CNT_W : atm_pkg::SLOT_W;

    atm_pkg::req_t     req_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  last_reg, last_next;
    atm_pkg::status_t  status_reg, status_next;
    logic              ring_reg, ring_next;
    logic [IDX_W-1:0]  rang_reg, rang_next;
    atm_pkg::entry_t   entry_reg, entry_next;
    atm_pkg::rsp_t     out_reg;

    logic [CMP_W-1:0]  slot_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CMP_W-1:0]  count_out_ext;
    logic [CMP_W-1:0]  rang_ext;
    logic [CNT_W-1:0]  idx_p1;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    atm_pkg::entry_t   wr_data;
    atm_pkg::entry_t   rdata;
    logic              rdata_passed;
    logic              new_passed;

    assign slot_ext = CMP_W'(req_reg.slot);
    assign cnt_ext  = CMP_W'(count_reg);
    assign idx_p1   = idx_reg + CNT_W'(1);

    assign rdata_passed = atm_pkg::alarm_passed(rdata.hour, rdata.minute,
                                                req_reg.now_hour, req_reg.now_minute);
    assign new_passed   = atm_pkg::alarm_passed(req_reg.alarm_hour, req_reg.alarm_minute,
                                                req_reg.now_hour, req_reg.now_minute);

    assign flags.full     = (count_reg >= CNT_W'(ALARM_SLOTS));
    assign flags.bad_slot = (count_reg == '0) || (slot_ext >= cnt_ext);
    assign flags.idx_end  = (idx_reg >= count_reg);
    // count is already decremented here; shift while idx is below it
    assign flags.move_end = (idx_reg >= count_reg);
    assign flags.fire     = rdata_passed && !rdata.alerted;

    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = idx_reg[IDX_W-1:0];
        case (ctrl.cw.rd)
            atm_pkg::RD_IDX:    rd_addr = idx_reg[IDX_W-1:0];
            atm_pkg::RD_IDX_P1: rd_addr = idx_p1[IDX_W-1:0];
            atm_pkg::RD_SLOT:   rd_addr = slot_ext[IDX_W-1:0];
            default:            rd_en   = 1'b0;
        endcase
        last_next = rd_en ? rd_addr : last_reg;

        wr_en   = 1'b1;
        wr_addr = idx_reg[IDX_W-1:0];
        wr_data = rdata;
        case (ctrl.cw.wr)
            atm_pkg::WR_ADD:
            begin
                wr_addr = count_reg[IDX_W-1:0];
                wr_data = '{hour: req_reg.alarm_hour, minute: req_reg.alarm_minute,
                            alerted: new_passed};
            end
            atm_pkg::WR_MOVE:
            begin
                wr_addr = idx_reg[IDX_W-1:0];
                wr_data = rdata;
            end
            atm_pkg::WR_CHECK:
            begin
                wr_addr = last_reg;
                wr_data = '{hour: rdata.hour, minute: rdata.minute, alerted: rdata_passed};
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase

        case (ctrl.cw.idx)
            atm_pkg::IDX_ZERO: idx_next = '0;
            atm_pkg::IDX_SLOT: idx_next = slot_ext[CNT_W-1:0];
            atm_pkg::IDX_INC:  idx_next = idx_p1;
            default:           idx_next = idx_reg;
        endcase

        case (ctrl.cw.cnt)
            atm_pkg::CNT_INC: count_next = count_reg + CNT_W'(1);
            atm_pkg::CNT_DEC: count_next = count_reg - CNT_W'(1);
            default:          count_next = count_reg;
        endcase

        status_next = status_reg;
        ring_next   = ring_reg;
        rang_next   = rang_reg;
        entry_next  = entry_reg;
        if (ctrl.start)
        begin
            status_next = atm_pkg::STAT_OK;
            ring_next   = 1'b0;
            rang_next   = '0;
            entry_next  = '0;
        end
        else
        begin
            case (ctrl.cw.res)
                atm_pkg::RES_FULL:  status_next = atm_pkg::STAT_FULL;
                atm_pkg::RES_BAD:   status_next = atm_pkg::STAT_BAD;
                atm_pkg::RES_RING:
                begin
                    ring_next = 1'b1;
                    rang_next = last_reg;
                end
                atm_pkg::RES_ENTRY: entry_next = rdata;
                default:            ;
            endcase
        end
    end

    assign count_out_ext = CMP_W'(count_next);
    assign rang_ext      = CMP_W'(rang_next);

    atm_ram #(
        .WIDTH ($bits(atm_pkg::entry_t)),
        .DEPTH (ALARM_SLOTS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            req_reg <= req_data;
        end
        idx_reg    <= idx_next;
        last_reg   <= last_next;
        status_reg <= status_next;
        ring_reg   <= ring_next;
        rang_reg   <= rang_next;
        entry_reg  <= entry_next;
        if (ctrl.load)
        begin
            out_reg.status        <= status_next;
            out_reg.ring          <= ring_next;
            out_reg.rang_slot     <= rang_ext[atm_pkg::SLOT_W-1:0];
            out_reg.alarm_count   <= count_out_ext[atm_pkg::COUNT_W-1:0];
            out_reg.entry_hour    <= entry_next.hour;
            out_reg.entry_minute  <= entry_next.minute;
            out_reg.entry_alerted <= entry_next.alerted;
        end
    end

    assign rsp_data = out_reg;
endmodule

[rtl/core/alarm_table_matcher.sv]
// Alarm table matcher top level: microcoded sequencer plus table datapath.
// Depends on atm_pkg, atm_if, atm_seq, atm_dp (and atm_ram through atm_dp).
//
//   Port   Dir   Payload          Handshake
//   req    in    atm_pkg::req_t   valid/ready, one request per item
//   rsp    out   atm_pkg::rsp_t   valid/ready, one response per request
//
// One request at a time; req.ready is high while the sequencer is idle.
// Read and delete answer a bad slot with STAT_BAD. Delete shifts down the entries
// above the deleted slot, and check walks the table from entry 0 until one rings
// or all entries are walked; the two-step read-then-write loop around the
// registered table read sets the pace of both walks.
// A finished response waits in the output register; a new request is taken
// meanwhile. If that register is still full at the next finish, the
// sequencer holds. Reset clears the entry count; table contents are not reset.
module alarm_table_matcher #(
    parameter int ALARM_SLOTS = 20
) (
    input  logic             clk,
    input  logic             rst_n,
    atm_req_if.sink          req,
    atm_rsp_if.source        rsp
);
    atm_pkg::seq_ctrl_t ctrl;
    atm_pkg::dp_flags_t flags;

    atm_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_command (req.data.command),
        .req_ready   (req.ready),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .flags       (flags),
        .ctrl        (ctrl)
    );

    atm_dp #(
        .ALARM_SLOTS (ALARM_SLOTS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .req_data (req.data),
        .flags    (flags),
        .rsp_data (rsp.data)
    );
endmodule

[rtl/core/atm_chk.sv]
// Port-level checks for the alarm table matcher, bound to the top level.
// Depends on atm_pkg.
module atm_chk #(
    parameter int ALARM_SLOTS = 20
) (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input atm_pkg::rsp_t rsp_data
);
    // one request in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while sequencer busy");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("stalled response dropped or changed");

    a_ring_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.ring |-> rsp_data.status == atm_pkg::STAT_OK)
        else $error("ring with error status");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status == atm_pkg::STAT_FULL
        |-> rsp_data.alarm_count == atm_pkg::COUNT_W'(ALARM_SLOTS))
        else $error("table full reported below capacity");
endmodule

bind alarm_table_matcher atm_chk #(
    .ALARM_SLOTS (ALARM_SLOTS)
) u_atm_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
